/* rtl/core/pbfp_pkg.sv */
// Shared types and constants for the protobuf field parser.
package pbfp_pkg;

  localparam int unsigned ID_W     = 32;
  localparam int unsigned WT_W     = 3;
  localparam int unsigned VAL_W    = 64;
  localparam int unsigned ST_W     = 2;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = ID_W + VAL_W;
  localparam int unsigned OUT_TUSER_W = WT_W + ST_W;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_TRUNC    = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_t;

  localparam logic [WT_W-1:0] WT_VARINT  = 3'd0;
  localparam logic [WT_W-1:0] WT_FIXED64 = 3'd1;
  localparam logic [WT_W-1:0] WT_LEN     = 3'd2;
  localparam logic [WT_W-1:0] WT_FIXED32 = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    status_t            status;
    logic [VAL_W-1:0]   value;
    logic [WT_W-1:0]    wire_type;
    logic [ID_W-1:0]    field_num;
  } result_t;

endpackage

/* rtl/core/pbfp_in_reg.sv */
// Input register stage: holds one byte word until the core takes it.
module pbfp_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  pbfp_pkg::in_word_t s_word,
  input  logic              advance,
  output logic              held_valid,
  output pbfp_pkg::in_word_t held_word
);

  assign s_tready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      held_word <= s_word;
    end
  end

endmodule

/* rtl/core/pbfp_core.sv */
// Parser state and per-byte step logic for tag, varint, fixed and length fields.
module pbfp_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  pbfp_pkg::in_word_t word,
  output logic               emit,
  output pbfp_pkg::result_t  res
);

  typedef enum logic [2:0] {
    PH_TAG     = 3'd0,
    PH_VARVAL  = 3'd1,
    PH_FIXED   = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  localparam logic [6:0] SHIFT_LIMIT = 7'd70;

  phase_t                        phase, phase_next;
  logic [6:0]                    shift_amount, shift_amount_next;
  logic [pbfp_pkg::VAL_W-1:0]    accumulator, accumulator_next;
  logic [pbfp_pkg::ID_W-1:0]     held_field_num, held_field_num_next;
  logic [pbfp_pkg::WT_W-1:0]     held_wire_type, held_wire_type_next;
  logic [pbfp_pkg::VAL_W-1:0]    bytes_remaining, bytes_remaining_next;

  logic [pbfp_pkg::VAL_W-1:0]    vi_acc;
  logic [6:0]                    vi_shift;
  logic                          vi_done;
  logic                          vi_long;
  logic [pbfp_pkg::VAL_W-1:0]    fix_acc;
  logic [pbfp_pkg::VAL_W-1:0]    rem_dec;
  logic [pbfp_pkg::WT_W-1:0]     tag_wt;
  logic [pbfp_pkg::ID_W-1:0]     tag_id;

  // varint accumulate: 7 payload bits per byte, bits past 64 dropped
  always_comb begin
    vi_acc = accumulator;
    if (shift_amount < 7'd64) begin
      vi_acc = accumulator |
               ({{(pbfp_pkg::VAL_W-7){1'b0}}, word.data_byte[6:0]} << shift_amount[5:0]);
    end
    vi_shift = shift_amount + 7'd7;
    vi_done  = !word.data_byte[7];
    vi_long  = word.data_byte[7] && (vi_shift >= SHIFT_LIMIT);
  end

  assign fix_acc = accumulator |
                   ({{(pbfp_pkg::VAL_W-8){1'b0}}, word.data_byte} << shift_amount[5:0]);
  assign rem_dec = bytes_remaining - 64'd1;
  assign tag_wt  = vi_acc[pbfp_pkg::WT_W-1:0];
  assign tag_id  = vi_acc[pbfp_pkg::WT_W +: pbfp_pkg::ID_W];

  always_comb begin
    phase_next           = phase;
    shift_amount_next    = shift_amount;
    accumulator_next     = accumulator;
    held_field_num_next  = held_field_num;
    held_wire_type_next  = held_wire_type;
    bytes_remaining_next = bytes_remaining;
    emit                 = 1'b0;
    res.field_num        = held_field_num;
    res.wire_type        = held_wire_type;
    res.value            = '0;
    res.status           = pbfp_pkg::ST_OK;

    unique case (phase)
      PH_VARVAL: begin
        accumulator_next  = vi_acc;
        shift_amount_next = vi_shift;
        if (vi_long) begin
          emit       = 1'b1;
          res.status = pbfp_pkg::ST_TOO_LONG;
        end else if (vi_done) begin
          emit      = 1'b1;
          res.value = vi_acc;
        end else if (word.last_byte) begin
          emit       = 1'b1;
          res.status = pbfp_pkg::ST_TRUNC;
        end
      end
      PH_FIXED: begin
        accumulator_next     = fix_acc;
        shift_amount_next    = shift_amount + 7'd8;
        bytes_remaining_next = rem_dec;
        if (rem_dec == '0) begin
          emit      = 1'b1;
          res.value = fix_acc;
        end else if (word.last_byte) begin
          emit       = 1'b1;
          res.status = pbfp_pkg::ST_TRUNC;
        end
      end
      PH_LEN: begin
        accumulator_next  = vi_acc;
        shift_amount_next = vi_shift;
        if (vi_long) begin
          emit       = 1'b1;
          res.status = pbfp_pkg::ST_TOO_LONG;
        end else if (vi_done) begin
          if (vi_acc == '0) begin
            emit = 1'b1;
          end else if (word.last_byte) begin
            emit       = 1'b1;
            res.status = pbfp_pkg::ST_TRUNC;
          end else begin
            bytes_remaining_next = vi_acc;
            phase_next           = PH_PAYLOAD;
          end
        end else if (word.last_byte) begin
          emit       = 1'b1;
          res.status = pbfp_pkg::ST_TRUNC;
        end
      end
      PH_PAYLOAD: begin
        bytes_remaining_next = rem_dec;
        if (rem_dec == '0) begin
          emit      = 1'b1;
          res.value = accumulator;
        end else if (word.last_byte) begin
          emit       = 1'b1;
          res.status = pbfp_pkg::ST_TRUNC;
        end
      end
      default: begin
        // tag phase; unused codes land here too
        accumulator_next  = vi_acc;
        shift_amount_next = vi_shift;
        if (vi_long || !vi_done) begin
          phase_next    = PH_TAG;
          res.field_num = '0;
          res.wire_type = '0;
          if (vi_long) begin
            emit       = 1'b1;
            res.status = pbfp_pkg::ST_TOO_LONG;
          end else if (word.last_byte) begin
            emit       = 1'b1;
            res.status = pbfp_pkg::ST_TRUNC;
          end
        end else begin
          held_wire_type_next = tag_wt;
          held_field_num_next = tag_id;
          res.field_num       = tag_id;
          res.wire_type       = tag_wt;
          shift_amount_next   = '0;
          accumulator_next    = '0;
          unique case (tag_wt)
            pbfp_pkg::WT_VARINT: phase_next = PH_VARVAL;
            pbfp_pkg::WT_FIXED64: begin
              phase_next           = PH_FIXED;
              bytes_remaining_next = 64'd8;
            end
            pbfp_pkg::WT_FIXED32: begin
              phase_next           = PH_FIXED;
              bytes_remaining_next = 64'd4;
            end
            pbfp_pkg::WT_LEN: phase_next = PH_LEN;
            default: emit = 1'b1;
          endcase
          if (!emit && word.last_byte) begin
            emit       = 1'b1;
            res.status = pbfp_pkg::ST_TRUNC;
          end
        end
      end
    endcase

    if (emit) begin
      phase_next           = PH_TAG;
      shift_amount_next    = '0;
      accumulator_next     = '0;
      bytes_remaining_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_TAG;
      shift_amount    <= '0;
      accumulator     <= '0;
      held_field_num  <= '0;
      held_wire_type  <= '0;
      bytes_remaining <= '0;
    end else if (step) begin
      phase           <= phase_next;
      shift_amount    <= shift_amount_next;
      accumulator     <= accumulator_next;
      held_field_num  <= held_field_num_next;
      held_wire_type  <= held_wire_type_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

  a_shift_bound: assert property (@(posedge clk) disable iff (rst)
    shift_amount <= SHIFT_LIMIT)
    else $error("shift amount past varint limit");

  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> bytes_remaining != '0)
    else $error("payload phase with nothing left");

  a_fixed_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_FIXED |-> (bytes_remaining != '0 && bytes_remaining <= 64'd8))
    else $error("fixed field count out of range");

  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    step && emit |=> (phase == PH_TAG && accumulator == '0 && shift_amount == '0))
    else $error("no return to idle after result");

endmodule

/* rtl/core/pbfp_out_reg.sv */
// Result register: holds one result word until the sink takes it.
module pbfp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              emit,
  input  pbfp_pkg::result_t res,
  input  logic              m_tready,
  output logic              m_tvalid,
  output pbfp_pkg::result_t held_res,
  output logic              advance
);

  assign advance = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      held_res <= res;
    end
  end

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(held_res))
    else $error("result word changed while stalled");

  a_no_step_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !step)
    else $error("core stepped into a full result register");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    step && emit |=> m_tvalid)
    else $error("emitted result lost");

endmodule

/* rtl/core/protobuf_field_parser.sv */
// Top level of the protobuf wire-format field parser.
// Takes one encoded byte per word on s_* and gives one result word on m_* for each
// completed field (or error). Throughput is one byte per clock while the result
// register is not stalled by m_tready: a byte goes from the input register through
// the step logic into the result register, which then presents the result on m_*.
// The input register and the result register let the next byte be taken while a
// result waits for m_tready. Payload bytes of length-delimited fields are counted and
// dropped; status 1 marks a buffer that ends inside a field, status 2 a varint longer
// than ten bytes, and in both cases value is zero and the parser returns to the tag.
module protobuf_field_parser (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [pbfp_pkg::IN_TDATA_W-1:0]     s_tdata,   // [7:0] data_byte
  input  logic                                s_tlast,   // last_byte
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [pbfp_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [31:0] field number, [95:32] value
  output logic [pbfp_pkg::OUT_TUSER_W-1:0]    m_tuser    // [2:0] wire_type, [4:3] status
);

  pbfp_pkg::in_word_t s_word;
  pbfp_pkg::in_word_t held_word;
  pbfp_pkg::result_t  res;
  pbfp_pkg::result_t  held_res;
  logic               held_valid;
  logic               advance;
  logic               step;
  logic               emit;

  assign s_word.data_byte = s_tdata;
  assign s_word.last_byte = s_tlast;
  assign step             = held_valid && advance;

  pbfp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_word     (s_word),
    .advance    (advance),
    .held_valid (held_valid),
    .held_word  (held_word)
  );

  pbfp_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .word (held_word),
    .emit (emit),
    .res  (res)
  );

  pbfp_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .emit     (emit),
    .res      (res),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .held_res (held_res),
    .advance  (advance)
  );

  assign m_tdata = {held_res.value, held_res.field_num};
  assign m_tuser = {held_res.status, held_res.wire_type};

endmodule

/* tb/tb_protobuf_field_parser.sv */
// Self-checking testbench for the protobuf wire-format field parser.
`timescale 1ns / 1ps

module tb_protobuf_field_parser;

  localparam int RANDOM_BYTES = 1700;
  localparam int TAIL_BYTES   = 150;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;

  typedef enum logic [2:0] {
    P_TAG, P_VARVAL, P_FIXED, P_LEN, P_PAYLOAD
  } parse_phase_t;

  typedef enum logic [1:0] {VB_MORE, VB_DONE, VB_LONG} varint_step_t;

  logic                             clk      = 1'b0;
  logic                             rst      = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [pbfp_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                             s_tlast  = 1'b0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [pbfp_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic [pbfp_pkg::OUT_TUSER_W-1:0] m_tuser;

  protobuf_field_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // parser state mirror
  parse_phase_t pr_phase;
  logic [6:0]   pr_shift;
  logic [63:0]  pr_acc;
  logic [31:0]  pr_id;
  logic [2:0]   pr_wt;
  logic [63:0]  pr_left;

  pbfp_pkg::result_t  expected_fields[$];
  pbfp_pkg::in_word_t pending_bytes[$];
  logic [7:0]         msg_bytes[$];

  int mismatches     = 0;
  int bytes_sent     = 0;
  int fields_checked = 0;
  int n_trunc        = 0;
  int n_long         = 0;
  int stall_cycles   = 0;
  int cycle_count    = 0;
  int src_rate       = 10;
  int sink_rate      = 10;
  int src_gap        = 0;
  int sink_gap       = 0;

  function automatic void return_to_tag();
    pr_phase = P_TAG;
    pr_shift = '0;
    pr_acc   = '0;
    pr_left  = '0;
  endfunction

  function automatic void post_field(logic [31:0] id, logic [2:0] wt, logic [63:0] val,
                                     pbfp_pkg::status_t st);
    pbfp_pkg::result_t r;
    r.field_num = id;
    r.wire_type = wt;
    r.value     = val;
    r.status    = st;
    expected_fields.push_back(r);
    return_to_tag();
  endfunction

  function automatic varint_step_t take_varint_byte(logic [7:0] b);
    if (pr_shift < 7'd64) pr_acc = pr_acc | ({57'd0, b[6:0]} << pr_shift);
    pr_shift = pr_shift + 7'd7;
    if (!b[7]) return VB_DONE;
    if (pr_shift >= 7'd70) return VB_LONG;
    return VB_MORE;
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic eob);
    varint_step_t r;
    case (pr_phase)
      P_VARVAL: begin
        r = take_varint_byte(b);
        if (r == VB_LONG) post_field(pr_id, pr_wt, '0, pbfp_pkg::ST_TOO_LONG);
        else if (r == VB_DONE) post_field(pr_id, pr_wt, pr_acc, pbfp_pkg::ST_OK);
        else if (eob) post_field(pr_id, pr_wt, '0, pbfp_pkg::ST_TRUNC);
      end
      P_FIXED: begin
        pr_acc   = pr_acc | ({56'd0, b} << pr_shift[5:0]);
        pr_shift = pr_shift + 7'd8;
        pr_left  = pr_left - 64'd1;
        if (pr_left == 0) post_field(pr_id, pr_wt, pr_acc, pbfp_pkg::ST_OK);
        else if (eob) post_field(pr_id, pr_wt, '0, pbfp_pkg::ST_TRUNC);
      end
      P_LEN: begin
        r = take_varint_byte(b);
        if (r == VB_LONG) begin
          post_field(pr_id, pr_wt, '0, pbfp_pkg::ST_TOO_LONG);
        end else if (r == VB_DONE) begin
          if (pr_acc == 0) post_field(pr_id, pr_wt, '0, pbfp_pkg::ST_OK);
          else if (eob) post_field(pr_id, pr_wt, '0, pbfp_pkg::ST_TRUNC);
          else begin
            pr_left  = pr_acc;
            pr_phase = P_PAYLOAD;
          end
        end else if (eob) begin
          post_field(pr_id, pr_wt, '0, pbfp_pkg::ST_TRUNC);
        end
      end
      P_PAYLOAD: begin
        pr_left = pr_left - 64'd1;
        if (pr_left == 0) post_field(pr_id, pr_wt, pr_acc, pbfp_pkg::ST_OK);
        else if (eob) post_field(pr_id, pr_wt, '0, pbfp_pkg::ST_TRUNC);
      end
      default: begin
        r = take_varint_byte(b);
        if (r == VB_LONG) begin
          post_field('0, '0, '0, pbfp_pkg::ST_TOO_LONG);
        end else if (r == VB_MORE) begin
          if (eob) post_field('0, '0, '0, pbfp_pkg::ST_TRUNC);
        end else begin
          pr_wt    = pr_acc[2:0];
          pr_id    = pr_acc[34:3];
          pr_shift = '0;
          pr_acc   = '0;
          case (pr_wt)
            pbfp_pkg::WT_VARINT:  pr_phase = P_VARVAL;
            pbfp_pkg::WT_FIXED64: begin
              pr_phase = P_FIXED;
              pr_left  = 64'd8;
            end
            pbfp_pkg::WT_FIXED32: begin
              pr_phase = P_FIXED;
              pr_left  = 64'd4;
            end
            pbfp_pkg::WT_LEN:     pr_phase = P_LEN;
            default:    post_field(pr_id, pr_wt, '0, pbfp_pkg::ST_OK);
          endcase
          if (pr_phase != P_TAG && eob) post_field(pr_id, pr_wt, '0, pbfp_pkg::ST_TRUNC);
        end
      end
    endcase
  endfunction

  // minimal length, sometimes padded out to up to ten bytes, with possible junk above bit 63
  function automatic void put_varint(logic [63:0] v);
    int n;
    logic [6:0] grp;
    n = 1;
    while (n < 10 && (v >> (7 * n)) != 0) n++;
    if ($urandom_range(0, 7) == 0) n = $urandom_range(n, 10);
    for (int i = 0; i < n; i++) begin
      if (i == 9) grp = {($urandom_range(0, 1) != 0) ? 6'($urandom) : 6'd0, v[63]};
      else grp = 7'(v >> (7 * i));
      msg_bytes.push_back({(i < n - 1) ? 1'b1 : 1'b0, grp});
    end
  endfunction

  function automatic void put_raw(int n);
    int fill;
    fill = $urandom_range(0, 5);
    for (int i = 0; i < n; i++)
      msg_bytes.push_back(fill == 0 ? 8'hff : fill == 1 ? 8'h00 : 8'($urandom));
  endfunction

  function automatic void put_field();
    logic [31:0] id;
    logic [2:0]  wt;
    logic [28:0] upper;
    logic [63:0] v;
    int          len;
    case ($urandom_range(0, 4))
      0:       id = $urandom_range(1, 15);
      1:       id = 32'hffff_ffff;
      2:       id = $urandom;
      3:       id = $urandom >> $urandom_range(0, 31);
      default: id = '0;
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2: wt = pbfp_pkg::WT_VARINT;
      3, 4:    wt = pbfp_pkg::WT_FIXED64;
      5, 6:    wt = pbfp_pkg::WT_FIXED32;
      7, 8:    wt = pbfp_pkg::WT_LEN;
      default: begin
        do wt = 3'($urandom_range(0, 7));
        while (wt inside {pbfp_pkg::WT_VARINT, pbfp_pkg::WT_FIXED64,
                          pbfp_pkg::WT_LEN, pbfp_pkg::WT_FIXED32});
      end
    endcase
    upper = ($urandom_range(0, 7) == 0) ? 29'($urandom) : 29'd0;
    put_varint({upper, id, wt});
    case (wt)
      pbfp_pkg::WT_VARINT: begin
        case ($urandom_range(0, 5))
          0:       v = 64'($urandom_range(0, 127));
          1:       v = '1;
          2:       v = 64'd1 << $urandom_range(0, 63);
          3:       v = {$urandom, $urandom};
          4:       v = {$urandom, $urandom} >> $urandom_range(0, 63);
          default: v = '0;
        endcase
        put_varint(v);
      end
      pbfp_pkg::WT_FIXED64: put_raw(8);
      pbfp_pkg::WT_FIXED32: put_raw(4);
      pbfp_pkg::WT_LEN: begin
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 300) : $urandom_range(0, 12);
        put_varint(64'(len));
        put_raw(len);
      end
      default: ;
    endcase
  endfunction

  function automatic void flush_frame(int cut);
    pbfp_pkg::in_word_t w;
    for (int i = 0; i < cut; i++) begin
      w.data_byte = msg_bytes[i];
      w.last_byte = (i == cut - 1);
      pending_bytes.push_back(w);
    end
    msg_bytes.delete();
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("mismatch at result %0d: %s got 0x%0h want 0x%0h",
             fields_checked, what, got, want);
  endtask

  always @(posedge clk) begin : source
    pbfp_pkg::in_word_t w;
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        decode_byte(s_tdata, s_tlast);
        bytes_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (src_gap != 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_bytes.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (pending_bytes.size() > TAIL_BYTES &&
                     $urandom_range(0, 99) < src_rate) begin
          src_gap = $urandom_range(0, 6);
          s_tvalid <= 1'b0;
        end else begin
          w = pending_bytes.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= w.data_byte;
          s_tlast  <= w.last_byte;
        end
      end
    end
  end

  always @(posedge clk) begin : sink
    pbfp_pkg::result_t got;
    pbfp_pkg::result_t want;
    if (rst) begin
      m_tready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.field_num = m_tdata[pbfp_pkg::ID_W-1:0];
        got.value     = m_tdata[pbfp_pkg::ID_W +: pbfp_pkg::VAL_W];
        got.wire_type = m_tuser[pbfp_pkg::WT_W-1:0];
        got.status    = pbfp_pkg::status_t'(m_tuser[pbfp_pkg::WT_W +: pbfp_pkg::ST_W]);
        if (expected_fields.size() == 0) begin
          report_mismatch("word with no field pending, value", got.value, '0);
        end else begin
          want = expected_fields.pop_front();
          if (got.field_num !== want.field_num)
            report_mismatch("field number", 64'(got.field_num), 64'(want.field_num));
          if (got.wire_type !== want.wire_type)
            report_mismatch("wire_type", 64'(got.wire_type), 64'(want.wire_type));
          if (got.value !== want.value)
            report_mismatch("value", got.value, want.value);
          if (got.status !== want.status)
            report_mismatch("status", 64'(got.status), 64'(want.status));
          fields_checked++;
          case (want.status)
            pbfp_pkg::ST_TRUNC:    n_trunc++;
            pbfp_pkg::ST_TOO_LONG: n_long++;
            default:     ;
          endcase
        end
      end
      if (sink_gap != 0) begin
        sink_gap--;
        m_tready <= 1'b0;
      end else if (pending_bytes.size() > TAIL_BYTES && $urandom_range(0, 99) < sink_rate) begin
        sink_gap = $urandom_range(0, 6);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // idle rates are redrawn in the watchdog block; a rate of 0 gives a stretch with no idling
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count % 100 == 0) begin
      src_rate  <= 10 * $urandom_range(0, 3);
      sink_rate <= 10 * $urandom_range(0, 3);
    end
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("tb_protobuf_field_parser: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int kind;
    return_to_tag();
    pr_id = '0;
    pr_wt = '0;

    // varint, fixed64, fixed32, zero length, short payload, unknown type with last
    msg_bytes = {8'h08, 8'h00,
                 8'h11, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                 8'h1d, 8'h00, 8'h00, 8'h00, 8'h00,
                 8'h22, 8'h00,
                 8'h2a, 8'h02, 8'haa, 8'h55,
                 8'h1b};
    flush_frame(msg_bytes.size());
    // buffer ends inside the tag, then inside a varint value
    msg_bytes = {8'h80};
    flush_frame(1);
    msg_bytes = {8'h08, 8'h81};
    flush_frame(2);

    while (pending_bytes.size() < RANDOM_BYTES) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        repeat ($urandom_range(1, 4)) put_field();
        flush_frame(msg_bytes.size());
      end else if (kind < 82) begin
        repeat ($urandom_range(1, 3)) put_field();
        flush_frame($urandom_range(1, msg_bytes.size()));
      end else if (kind < 90) begin
        if ($urandom_range(0, 1) != 0) put_field();
        if ($urandom_range(0, 1) != 0)
          put_varint({29'd0, 32'($urandom),
                      ($urandom_range(0, 1) != 0) ? pbfp_pkg::WT_VARINT : pbfp_pkg::WT_LEN});
        repeat ($urandom_range(10, 12)) msg_bytes.push_back({1'b1, 7'($urandom)});
        if ($urandom_range(0, 1) != 0) put_field();
        flush_frame(msg_bytes.size());
      end else begin
        repeat ($urandom_range(1, 16)) msg_bytes.push_back(8'($urandom));
        flush_frame(msg_bytes.size());
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_fields.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d bytes, checked %0d fields", bytes_sent, fields_checked);
    $display("%0d cut short, %0d with overlong varints, %0d mismatches",
             n_trunc, n_long, mismatches);
    if (mismatches == 0 && expected_fields.size() == 0)
      $display("tb_protobuf_field_parser: PASS");
    else
      $display("tb_protobuf_field_parser: FAIL");
    $finish;
  end

endmodule
